// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker module of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define JSU_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("jsu assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define JSU_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("jsu assertion failed");

`endif

// ===== hw/rtl/jsu_pkg.sv =====
// Package with the symbol codes and sequencer state codes of the Jacobi symbol unit.
package jsu_pkg;

    typedef logic signed [1:0] symbol_t;

    localparam symbol_t SYM_ZERO = 2'sb00;
    localparam symbol_t SYM_POS  = 2'sb01;
    localparam symbol_t SYM_NEG  = 2'sb11;

    localparam int OUT_TDATA_W = 8;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

endpackage

// ===== hw/rtl/jsu_step_unit.sv =====
// One step of the binary Jacobi loop: halve an even numerator, or subtract and swap.
module jsu_step_unit #(
    parameter int OPERAND_WIDTH = 31
) (
    input  logic [OPERAND_WIDTH-1:0] a_in,
    input  logic [OPERAND_WIDTH-1:0] n_in,
    input  logic                     neg_in,
    output logic [OPERAND_WIDTH-1:0] a_out,
    output logic [OPERAND_WIDTH-1:0] n_out,
    output logic                     neg_out
);

    logic                     a_ge_n;
    logic [OPERAND_WIDTH-1:0] big;
    logic [OPERAND_WIDTH-1:0] small_op;
    logic [OPERAND_WIDTH-1:0] diff;
    logic                     flip;

    // The single shared compare and subtract of the datapath.
    assign a_ge_n   = (a_in >= n_in);
    assign big      = a_ge_n ? a_in : n_in;
    assign small_op = a_ge_n ? n_in : a_in;
    assign diff     = big - small_op;

    always_comb begin
        if (!a_in[0]) begin
            // Factor of two: (2/n) is -1 when n is 3 or 5 mod 8.
            a_out = a_in >> 1;
            n_out = n_in;
            flip  = (n_in[2:0] == 3'd3) || (n_in[2:0] == 3'd5);
        end else begin
            // Both odd: reciprocity swap when a < n, then reduce by subtraction.
            a_out = diff;
            n_out = a_ge_n ? n_in : a_in;
            flip  = !a_ge_n && (a_in[1:0] == 2'd3) && (n_in[1:0] == 2'd3);
        end
    end

    assign neg_out = neg_in ^ flip;

endmodule

// ===== hw/rtl/jacobi_symbol_unit_top.sv =====
// Top level of the Jacobi symbol unit: stream ports, sequencer and result register.
//
//  channel | dir | handshake                    | word contents
//  s_axis  | in  | s_axis_tvalid/s_axis_tready  | value_a, modulus_n
//  m_axis  | out | m_axis_tvalid/m_axis_tready  | symbol (tdata), invalid (tuser)
//
// One word runs through a single shared compare-and-subtract step, one step per cycle.
// Each step halves the numerator or subtracts the smaller operand, and every subtraction
// is followed by a halving.
// An even or zero modulus skips the steps and finishes with invalid set.
// Reset is synchronous and active low and clears the sequencer and output valid.
// A stalled result is held in the output register while the next word is taken.
module jacobi_symbol_unit_top import jsu_pkg::*; #(
    parameter int OPERAND_WIDTH = 31
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // value_a [OPERAND_WIDTH-1:0], modulus_n [2*OPERAND_WIDTH-1:OPERAND_WIDTH], zero pad
    input  logic [((2*OPERAND_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // symbol [1:0] (two's complement), zero pad [7:2]
    output logic [OUT_TDATA_W-1:0]                   m_axis_tdata,
    // invalid [0]
    output logic                                     m_axis_tuser
);

    logic                     state_reg, state_next;
    logic [OPERAND_WIDTH-1:0] a_reg, a_next;
    logic [OPERAND_WIDTH-1:0] n_reg, n_next;
    logic                     neg_reg, neg_next;
    logic                     inv_reg, inv_next;
    logic                     out_valid_reg, out_valid_next;
    symbol_t                  out_sym_reg, out_sym_next;
    logic                     out_inv_reg, out_inv_next;

    logic [OPERAND_WIDTH-1:0] step_a;
    logic [OPERAND_WIDTH-1:0] step_n;
    logic                     step_neg;
    logic                     in_accept;
    logic                     done;
    logic                     out_free;
    symbol_t                  result_sym;

    jsu_step_unit #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_step (
        .a_in   (a_reg),
        .n_in   (n_reg),
        .neg_in (neg_reg),
        .a_out  (step_a),
        .n_out  (step_n),
        .neg_out(step_neg)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // The loop ends when the numerator reaches zero; an invalid modulus ends at once.
    assign done     = inv_reg || (a_reg == '0);
    assign out_free = !out_valid_reg || m_axis_tready;

    // The symbol is the collected sign when the modulus ends at one, otherwise zero.
    always_comb begin
        if (inv_reg) begin
            result_sym = SYM_ZERO;
        end else if (n_reg == OPERAND_WIDTH'(1)) begin
            result_sym = neg_reg ? SYM_NEG : SYM_POS;
        end else begin
            result_sym = SYM_ZERO;
        end
    end

    always_comb begin
        state_next     = state_reg;
        a_next         = a_reg;
        n_next         = n_reg;
        neg_next       = neg_reg;
        inv_next       = inv_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_sym_next   = out_sym_reg;
        out_inv_next   = out_inv_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    a_next     = s_axis_tdata[OPERAND_WIDTH-1:0];
                    n_next     = s_axis_tdata[2*OPERAND_WIDTH-1:OPERAND_WIDTH];
                    neg_next   = 1'b0;
                    // Zero is even, so bit 0 alone flags a bad modulus.
                    inv_next   = !s_axis_tdata[OPERAND_WIDTH];
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (done) begin
                    if (out_free) begin
                        out_valid_next = 1'b1;
                        out_sym_next   = result_sym;
                        out_inv_next   = inv_reg;
                        state_next     = ST_IDLE;
                    end
                end else begin
                    a_next   = step_a;
                    n_next   = step_n;
                    neg_next = step_neg;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg       <= a_next;
        n_reg       <= n_next;
        neg_reg     <= neg_next;
        inv_reg     <= inv_next;
        out_sym_reg <= out_sym_next;
        out_inv_reg <= out_inv_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-2){1'b0}}, out_sym_reg};
    assign m_axis_tuser  = out_inv_reg;

endmodule

// ===== hw/rtl/jsu_checker.sv =====
// Port-level checker for the Jacobi symbol unit and its bind to the top level.
`include "assert_macros.svh"

module jsu_checker import jsu_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tuser
);

    // An invalid modulus always reports a zero symbol.
    `JSU_ASSERT_NOW(a_inv_zero, aclk, aresetn, m_axis_tvalid && m_axis_tuser, m_axis_tdata[1:0] == SYM_ZERO)

    // Only the codes for -1, 0 and 1 appear, with clean padding.
    `JSU_ASSERT_NOW(a_sym_code, aclk, aresetn, m_axis_tvalid, (m_axis_tdata[1:0] != 2'b10) && (m_axis_tdata[OUT_TDATA_W-1:2] == '0))

    // The unit works on one word at a time: taking a word closes the input.
    `JSU_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // A stalled result word holds.
    `JSU_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind jacobi_symbol_unit_top jsu_checker u_jsu_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);
